FILE: hdl/tlg_pkg.sv
// shared types and constants for the toroidal life generation core
// no dependencies
`timescale 1ns / 1ps

package tlg_pkg;

  localparam int unsigned DEF_MAX_ROWS = 64;
  localparam int unsigned DEF_MAX_COLS = 64;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned GEN_W     = 16;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]        command;
    logic [5:0]        row_number;
    logic [WORD_W-1:0] row_word;
    logic [GEN_W-1:0]  generation_count;
  } tlg_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] row_cells;
    logic [5:0]        echoed_row;
    logic [1:0]        echoed_command;
  } tlg_rsp_t;

endpackage

FILE: hdl/tlg_row_update.sv
// one row of b3/s23 cell updaters on a column ring of variable length
// depends on nothing outside this file
`timescale 1ns / 1ps

module tlg_row_update #(
  parameter int unsigned MAX_COLS = 64
) (
  input  logic [MAX_COLS-1:0] up_i,
  input  logic [MAX_COLS-1:0] mid_i,
  input  logic [MAX_COLS-1:0] dn_i,
  input  logic [MAX_COLS-1:0] mask_i,
  input  logic [MAX_COLS-1:0] top_sel_i,
  output logic [MAX_COLS-1:0] next_o
);

  localparam logic [3:0] NBR_KEEP = 4'd2;
  localparam logic [3:0] NBR_BORN = 4'd3;

  // bit k takes bit k-1, bit 0 takes the last column in use
  function automatic logic [MAX_COLS-1:0] rot_up(input logic [MAX_COLS-1:0] x,
                                                 input logic [MAX_COLS-1:0] m,
                                                 input logic [MAX_COLS-1:0] sel);
    logic [MAX_COLS-1:0] r;
    r = (x << 1) & m;
    r[0] = r[0] | (|(x & sel));
    return r;
  endfunction

  // bit k takes bit k+1, the last column in use takes bit 0
  function automatic logic [MAX_COLS-1:0] rot_dn(input logic [MAX_COLS-1:0] x,
                                                 input logic [MAX_COLS-1:0] sel);
    return (x >> 1) | (sel & {MAX_COLS{x[0]}});
  endfunction

  logic [MAX_COLS-1:0] u, m, d;
  logic [MAX_COLS-1:0] u_l, u_r, m_l, m_r, d_l, d_r;
  logic [MAX_COLS-1:0] live;
  logic [3:0]          cnt;

  always_comb begin
    u   = up_i & mask_i;
    m   = mid_i & mask_i;
    d   = dn_i & mask_i;
    u_l = rot_up(u, mask_i, top_sel_i);
    u_r = rot_dn(u, top_sel_i);
    m_l = rot_up(m, mask_i, top_sel_i);
    m_r = rot_dn(m, top_sel_i);
    d_l = rot_up(d, mask_i, top_sel_i);
    d_r = rot_dn(d, top_sel_i);
    cnt = '0;
    for (int k = 0; k < MAX_COLS; k++) begin
      cnt = 4'(u_l[k]) + 4'(u[k]) + 4'(u_r[k]) + 4'(m_l[k]) + 4'(m_r[k])
          + 4'(d_l[k]) + 4'(d[k]) + 4'(d_r[k]);
      live[k] = (cnt == NBR_BORN) || ((cnt == NBR_KEEP) && m[k]);
    end
    next_o = (mid_i & ~mask_i) | (live & mask_i);
  end

endmodule

FILE: hdl/toroidal_life_generation_core.sv
// toroidal life generation core: b3/s23 grid with row write, row read and advance
// depends on tlg_pkg and tlg_row_update
`timescale 1ns / 1ps

// Requests arrive on in_valid_i/in_ready_o carrying a tlg_req_t; each request
// gives exactly one response on out_valid_o/out_ready_i as a tlg_rsp_t.
// Registers (row_count, column_count) are written through cfg_we_i with
// cfg_idx_i selecting the register; writes take effect on the next cycle.
// The grid lives in one memory of MAX_ROWS words, one read and one write port.
// One generation streams the rows through a single row updater, one row per
// cycle, once the last and first rows prime the window; the read port sets this.
// One request is in work at a time; in_ready_o is high only while idle. A
// finished response waits in the output register while the receiver stalls,
// and the next request is still accepted meanwhile.
// After reset the grid is zeroed by a clearing pass over min(MAX_ROWS, 127)
// rows with in_ready_o low; register writes are taken during the pass.
module toroidal_life_generation_core #(
  parameter int unsigned MAX_ROWS = tlg_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = tlg_pkg::DEF_MAX_COLS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlg_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tlg_pkg::tlg_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tlg_pkg::tlg_rsp_t              out_rsp_o
);

  import tlg_pkg::*;

  localparam int unsigned CFG_MAX   = (1 << CFG_W) - 1;
  localparam int unsigned ROW_LIMIT = (MAX_ROWS < CFG_MAX) ? MAX_ROWS : CFG_MAX;
  localparam int unsigned AW        = $clog2(MAX_ROWS);
  localparam int unsigned RCW       = $clog2(ROW_LIMIT + 1);
  localparam int unsigned TW        = RCW + 1;
  localparam int unsigned CCW       = $clog2(MAX_COLS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_GEN,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [CFG_W-1:0]    row_count_q, col_count_q;
  logic [AW-1:0]       clr_q;
  logic [TW-1:0]       t_q;
  logic [GEN_W-1:0]    gen_left_q;
  logic [1:0]          cmd_q;
  logic [5:0]          row_q;
  logic                hit_q;
  logic [MAX_COLS-1:0] cells_q;
  logic                out_valid_q;
  tlg_rsp_t            out_q;

  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata_q;
  logic [MAX_COLS-1:0] up_q, mid_q, first_q;

  logic [RCW-1:0]      rows;
  logic [AW-1:0]       rows_last;
  logic [CCW-1:0]      cols;
  logic [MAX_COLS-1:0] col_mask, top_sel;
  logic                row_hit, in_fire, out_fire, out_load, gen_end, gen_wr;
  logic [MAX_COLS-1:0] dn_row, new_row;
  logic                mem_we;
  logic [AW-1:0]       mem_wa, mem_ra;
  logic [MAX_COLS-1:0] mem_wd;

  // rows and columns in use, saturated to the legal range
  always_comb begin
    priority if (row_count_q == '0) begin
      rows = RCW'(1);
    end else if (row_count_q > CFG_W'(ROW_LIMIT)) begin
      rows = RCW'(ROW_LIMIT);
    end else begin
      rows = RCW'(row_count_q);
    end
    priority if (col_count_q == '0) begin
      cols = CCW'(1);
    end else if (col_count_q > CFG_W'(MAX_COLS)) begin
      cols = CCW'(MAX_COLS);
    end else begin
      cols = CCW'(col_count_q);
    end
    rows_last = AW'(rows - RCW'(1));
    for (int k = 0; k < MAX_COLS; k++) begin
      col_mask[k] = CCW'(k) < cols;
      top_sel[k]  = CCW'(k) == (cols - CCW'(1));
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign row_hit    = CFG_W'(in_req_i.row_number) < CFG_W'(rows);
  assign gen_end    = (t_q == (TW'(rows) + TW'(2)));
  assign gen_wr     = (t_q >= TW'(3));
  assign dn_row     = gen_end ? first_q : rdata_q;

  tlg_row_update #(
    .MAX_COLS (MAX_COLS)
  ) u_row_update (
    .up_i      (up_q),
    .mid_i     (mid_q),
    .dn_i      (dn_row),
    .mask_i    (col_mask),
    .top_sel_i (top_sel),
    .next_o    (new_row)
  );

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_q;
    mem_wd = '0;
    mem_ra = rows_last;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_ra = AW'(in_req_i.row_number);
        if (in_fire && (in_req_i.command == CMD_WRITE) && row_hit) begin
          mem_we = 1'b1;
          mem_wa = AW'(in_req_i.row_number);
          mem_wd = in_req_i.row_word[MAX_COLS-1:0] & col_mask;
        end
      end
      ST_GEN: begin
        mem_ra = (t_q == '0) ? rows_last : AW'(t_q - TW'(1));
        if (gen_wr) begin
          mem_we = 1'b1;
          mem_wa = AW'(t_q - TW'(3));
          mem_wd = new_row;
        end
      end
      default: begin
        mem_ra = rows_last;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[mem_ra];
  end

  // row window: row above, current row, and the old first row for the wrap
  always_ff @(posedge clk_i) begin
    if (state_q == ST_GEN) begin
      priority if (t_q == TW'(1)) begin
        up_q <= rdata_q;
      end else if (t_q == TW'(2)) begin
        mid_q   <= rdata_q;
        first_q <= rdata_q;
      end else if (gen_wr) begin
        up_q  <= mid_q;
        mid_q <= rdata_q;
      end else begin
        up_q <= up_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      row_count_q <= CFG_W'(64);
      col_count_q <= CFG_W'(64);
      clr_q       <= '0;
      t_q         <= '0;
      gen_left_q  <= '0;
      cmd_q       <= '0;
      row_q       <= '0;
      hit_q       <= 1'b0;
      cells_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ROW_COUNT:    row_count_q <= cfg_wdata_i;
          REG_COLUMN_COUNT: col_count_q <= cfg_wdata_i;
          default:          row_count_q <= row_count_q;
        endcase
      end
      if (out_fire && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(ROW_LIMIT - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            cmd_q   <= in_req_i.command;
            row_q   <= in_req_i.row_number;
            hit_q   <= row_hit;
            cells_q <= '0;
            priority if (in_req_i.command == CMD_READ) begin
              state_q <= ST_READ;
            end else if ((in_req_i.command == CMD_ADVANCE) &&
                         (in_req_i.generation_count != '0)) begin
              gen_left_q <= in_req_i.generation_count;
              t_q        <= '0;
              state_q    <= ST_GEN;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_READ: begin
          cells_q <= hit_q ? (rdata_q & col_mask) : '0;
          state_q <= ST_DONE;
        end
        ST_GEN: begin
          if (gen_end) begin
            t_q <= '0;
            if (gen_left_q == GEN_W'(1)) begin
              state_q <= ST_DONE;
            end else begin
              gen_left_q <= gen_left_q - GEN_W'(1);
            end
          end else begin
            t_q <= t_q + TW'(1);
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_valid_q          <= 1'b1;
            out_q.row_cells      <= WORD_W'(cells_q);
            out_q.echoed_row     <= row_q;
            out_q.echoed_command <= cmd_q;
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: hdl/tlg_checker.sv
// port-level checks for the toroidal life generation core, bound to the top level
// depends on tlg_pkg and toroidal_life_generation_core
`timescale 1ns / 1ps

module tlg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input tlg_pkg::tlg_rsp_t              out_rsp_o
);

  import tlg_pkg::*;

  // stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  // only a read carries cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.echoed_command != CMD_READ) |-> out_rsp_o.row_cells == '0)
    else $error("cells on a non-read response");

  // busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // a new response follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("response without work");

endmodule

bind toroidal_life_generation_core tlg_checker u_tlg_checker (.*);

FILE: tb/sv/tb.sv
// self-checking testbench for toroidal_life_generation_core: row writes, row reads and
// b3/s23 generation advances checked against a cell-by-cell grid predictor
// depends on tlg_pkg and toroidal_life_generation_core
`timescale 1ns / 1ps

module tb;
  import tlg_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 1800;
  localparam int unsigned TAIL_CYCLES     = 8;
  // longest single request here is 65535 generations on one row
  localparam int unsigned WATCHDOG_LIMIT  = 1_000_000;
  localparam logic [WORD_W-1:0] ALL_ONES  = '1;
  localparam logic [1:0] CMD_UNKNOWN      = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  tlg_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  tlg_rsp_t out_rsp_o;

  toroidal_life_generation_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // grid predictor state, all cells dead after reset
  logic [WORD_W-1:0] model_grid [DEF_MAX_ROWS] = '{default: '0};
  logic [CFG_W-1:0] rows_cfg = 7'd64;
  logic [CFG_W-1:0] cols_cfg = 7'd64;

  tlg_req_t req_backlog_q [$];
  tlg_rsp_t rsp_due_q [$];
  tlg_rsp_t due_rsp;

  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned cmd_seen [4] = '{0, 0, 0, 0};
  longint unsigned gens_advanced = 0;
  int unsigned count_settings = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] ready_pattern = 16'hffff;
  int unsigned pattern_age = 0;
  logic [3:0] pattern_pos = '0;
  logic run_done = 1'b0;

  function automatic int unsigned clamp_count(logic [CFG_W-1:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic logic [WORD_W-1:0] column_mask(int unsigned c);
    if (c >= WORD_W) return ALL_ONES;
    return (64'd1 << c) - 64'd1;
  endfunction

  function automatic void advance_grid(int unsigned r, int unsigned c);
    logic [WORD_W-1:0] fresh [DEF_MAX_ROWS];
    int unsigned i, j, n, up, dn, lf, rt;
    for (i = 0; i < r; i++) begin
      up = (i == 0) ? r - 1 : i - 1;
      dn = (i + 1 >= r) ? 0 : i + 1;
      fresh[i] = model_grid[i];
      for (j = 0; j < c; j++) begin
        lf = (j == 0) ? c - 1 : j - 1;
        rt = (j + 1 >= c) ? 0 : j + 1;
        // each of the 8 positions counts, even when it wraps onto the cell itself
        n = model_grid[up][lf] + model_grid[up][j] + model_grid[up][rt]
          + model_grid[i][lf] + model_grid[i][rt]
          + model_grid[dn][lf] + model_grid[dn][j] + model_grid[dn][rt];
        fresh[i][j] = (n == 3) || (n == 2 && model_grid[i][j]);
      end
    end
    for (i = 0; i < r; i++) model_grid[i] = fresh[i];
  endfunction

  function automatic tlg_rsp_t predict_response(tlg_req_t req);
    tlg_rsp_t rsp;
    int unsigned r, c, g;
    logic [WORD_W-1:0] m;
    r = clamp_count(rows_cfg, DEF_MAX_ROWS);
    c = clamp_count(cols_cfg, DEF_MAX_COLS);
    m = column_mask(c);
    rsp.row_cells = '0;
    rsp.echoed_row = req.row_number;
    rsp.echoed_command = req.command;
    case (req.command)
      CMD_WRITE: begin
        if (req.row_number < r) model_grid[req.row_number] = req.row_word & m;
      end
      CMD_READ: begin
        if (req.row_number < r) rsp.row_cells = model_grid[req.row_number] & m;
      end
      CMD_ADVANCE: begin
        for (g = 0; g < req.generation_count; g++) advance_grid(r, c);
        gens_advanced += req.generation_count;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // driver: bursts of requests separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        rsp_due_q.push_back(predict_response(in_req_i));
        cmd_seen[in_req_i.command]++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 || req_backlog_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_req_i <= req_backlog_q.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // monitor: checks responses, stalls on a changing 16-bit ready pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_due_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected response, expected none, actual %p", $time, out_rsp_o);
      end else begin
        due_rsp = rsp_due_q.pop_front();
        results_checked++;
        if (out_rsp_o.row_cells !== due_rsp.row_cells) begin
          error_count++;
          $display("%0t: row_cells expected %h actual %h", $time,
                   due_rsp.row_cells, out_rsp_o.row_cells);
        end
        if (out_rsp_o.echoed_row !== due_rsp.echoed_row) begin
          error_count++;
          $display("%0t: echoed_row expected %0d actual %0d", $time,
                   due_rsp.echoed_row, out_rsp_o.echoed_row);
        end
        if (out_rsp_o.echoed_command !== due_rsp.echoed_command) begin
          error_count++;
          $display("%0t: echoed_command expected %0d actual %0d", $time,
                   due_rsp.echoed_command, out_rsp_o.echoed_command);
        end
      end
    end
    pattern_age++;
    if (pattern_age == 64) begin
      pattern_age = 0;
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hffff;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = 16'($urandom & $urandom);
        default: ready_pattern = 16'($urandom | $urandom);
      endcase
      ready_pattern[0] = 1'b1;
    end
    pattern_pos <= pattern_pos + 4'd1;
    out_ready_i <= ready_pattern[pattern_pos];
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  function automatic void queue_req(logic [1:0] cmd, logic [5:0] row,
                                    logic [WORD_W-1:0] word, logic [GEN_W-1:0] gens);
    tlg_req_t req;
    req.command = cmd;
    req.row_number = row;
    req.row_word = word;
    req.generation_count = gens;
    req_backlog_q.push_back(req);
  endfunction

  function automatic logic [WORD_W-1:0] random_row();
    logic [WORD_W-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 2))
      0: w = w & {$urandom, $urandom};
      1: w = w | {$urandom, $urandom};
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [GEN_W-1:0] random_gens(int unsigned r);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return (r <= 4) ? GEN_W'($urandom_range(100, 400)) : GEN_W'($urandom_range(1, 3));
      default: return (r <= 8) ? GEN_W'($urandom_range(1, 24)) : GEN_W'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_count();
    case ($urandom_range(0, 5))
      0: return CFG_W'($urandom_range(0, 4));
      1: return CFG_W'($urandom_range(5, 16));
      2: return CFG_W'($urandom_range(17, 63));
      3: return 7'd64;
      4: return CFG_W'($urandom_range(65, 127));
      default: return CFG_W'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ROW_COUNT) rows_cfg = val;
    else cols_cfg = val;
  endtask

  task automatic set_counts(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COLUMN_COUNT, cols);
    count_settings++;
  endtask

  task automatic drain_block();
    do @(posedge clk_i);
    while (req_backlog_q.size() != 0 || in_valid_i || rsp_due_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned random_items, r, i, k, n_noise;
    random_items = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full 64x64 grid: cleared read, edge bits, unknown command, zero advance, wrap
    set_counts(7'd64, 7'd64);
    queue_req(CMD_READ, 6'd0, '0, '0);
    queue_req(CMD_WRITE, 6'd0, ALL_ONES, '0);
    queue_req(CMD_WRITE, 6'd63, 64'h8000_0000_0000_0001, '0);
    queue_req(CMD_READ, 6'd0, '0, '0);
    queue_req(CMD_READ, 6'd63, '0, '0);
    queue_req(CMD_UNKNOWN, 6'd63, ALL_ONES, 16'hffff);
    queue_req(CMD_READ, 6'd63, '0, '0);
    queue_req(CMD_ADVANCE, 6'd0, '0, 16'd0);
    queue_req(CMD_ADVANCE, 6'd0, '0, 16'd1);
    queue_req(CMD_READ, 6'd63, '0, '0);
    queue_req(CMD_READ, 6'd0, '0, '0);
    queue_req(CMD_READ, 6'd1, '0, '0);
    drain_block();

    // zero counts act as one: the single cell sees itself eight times
    set_counts(7'd0, 7'd0);
    queue_req(CMD_WRITE, 6'd0, ALL_ONES, '0);
    queue_req(CMD_WRITE, 6'd5, ALL_ONES, '0);
    queue_req(CMD_READ, 6'd5, '0, '0);
    queue_req(CMD_ADVANCE, 6'd0, '0, 16'd1);
    queue_req(CMD_READ, 6'd0, '0, '0);
    drain_block();

    // oversized row count saturates, two columns
    set_counts(7'd127, 7'd2);
    queue_req(CMD_WRITE, 6'd2, ALL_ONES, '0);
    queue_req(CMD_ADVANCE, 6'd0, '0, 16'd2);
    queue_req(CMD_READ, 6'd1, '0, '0);
    queue_req(CMD_READ, 6'd2, '0, '0);
    drain_block();

    // maximum generation count on a one-row strip
    set_counts(7'd1, 7'd7);
    queue_req(CMD_WRITE, 6'd0, 64'h16, '0);
    queue_req(CMD_ADVANCE, 6'd0, '0, 16'hffff);
    queue_req(CMD_READ, 6'd0, '0, '0);
    drain_block();

    // random phases: mostly fill / advance / read-back episodes, some noise
    while (random_items < RANDOM_ITEMS) begin
      set_counts(random_count(), random_count());
      r = clamp_count(rows_cfg, DEF_MAX_ROWS);
      k = 0;
      while (k < 150) begin
        if ($urandom_range(0, 9) < 7) begin
          for (i = 0; i < r; i++) begin
            if ($urandom_range(0, 6) != 0) begin
              queue_req(CMD_WRITE, 6'(i), random_row(), GEN_W'($urandom));
              k++;
            end
          end
          queue_req(CMD_ADVANCE, 6'($urandom_range(0, 63)), random_row(), random_gens(r));
          k++;
          if ($urandom_range(0, 3) == 0) begin
            queue_req(CMD_ADVANCE, 6'($urandom_range(0, 63)), random_row(),
                      random_gens(r));
            k++;
          end
          for (i = 0; i < r; i++) begin
            queue_req(CMD_READ, 6'(i), random_row(), GEN_W'($urandom));
            k++;
          end
        end else begin
          n_noise = $urandom_range(1, 6);
          for (i = 0; i < n_noise; i++) begin
            queue_req(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), random_row(),
                      random_gens(r));
          end
          k += n_noise;
        end
      end
      random_items += k;
      drain_block();
    end
    run_done = 1'b1;
  end

  initial begin : finisher
    wait (run_done || idle_cycles >= WATCHDOG_LIMIT);
    if (!run_done) begin
      $display("%0t: no handshake for %0d cycles, %0d responses outstanding", $time,
               WATCHDOG_LIMIT, rsp_due_q.size());
    end else begin
      $display("checked %0d responses: %0d writes, %0d reads, %0d advances, %0d unknown",
               results_checked, cmd_seen[CMD_WRITE], cmd_seen[CMD_READ],
               cmd_seen[CMD_ADVANCE], cmd_seen[CMD_UNKNOWN]);
      $display("%0d generations over %0d grid size settings, %0d mismatches",
               gens_advanced, count_settings, error_count);
    end
    if (run_done && error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
